// File: sv/vced_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vced_pkg
// Shared types and constants for the voice change event detector: voice
// observation layout, event kinds, configuration and the item passed from the
// compare stage to the event emitter.
// ----------------------------------------------------------------------------
package vced_pkg;

  localparam int VOICE_COUNT = 8;
  localparam int VOICE_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int NUM_KINDS   = 9;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [7:0] CAPACITY_RESET = 8'd72;
  localparam logic [1:0] RELEASE_RESET  = 2'd0;

  // Register index decoded from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_RELEASE  = 1'b1;

  typedef enum logic [3:0] {
    KIND_KEYON   = 4'd0,
    KIND_RELEASE = 4'd1,
    KIND_END     = 4'd2,
    KIND_SOURCE  = 4'd3,
    KIND_PITCH   = 4'd4,
    KIND_VOLUME  = 4'd5,
    KIND_NOISE   = 4'd6,
    KIND_PMOD    = 4'd7,
    KIND_ECHO    = 4'd8
  } event_kind_t;

  typedef struct packed {
    logic [7:0] capacity;
    logic [1:0] release_code;
  } cfg_t;

  // The part of an observation that is kept per voice (45 bits).
  typedef struct packed {
    logic        active;
    logic [1:0]  phase;
    logic [7:0]  source;
    logic [14:0] pitch;
    logic [7:0]  vol_l;
    logic [7:0]  vol_r;
    logic [2:0]  flags;
  } voice_obs_t;

  typedef struct packed {
    logic [2:0]  voice_index;
    logic        frame_start;
    logic [47:0] frame_stamp;
    logic        voice_active;
    logic [1:0]  env_phase;
    logic [10:0] env_level;
    logic [7:0]  sample_source;
    logic [14:0] eff_pitch;
    logic [7:0]  vol_left;
    logic [7:0]  vol_right;
    logic [2:0]  voice_flags;
  } obs_word_t;

  typedef struct packed {
    logic [2:0]           voice;
    logic                 frame_start;
    logic [47:0]          stamp;
    logic [10:0]          level;
    voice_obs_t           cur;
    logic [7:0]           old_source;
    logic [14:0]          old_pitch;
    logic [NUM_KINDS-1:0] mask;
  } item_t;

  typedef struct packed {
    logic        event_valid;
    logic [3:0]  event_kind;
    logic [2:0]  event_voice;
    logic [47:0] event_stamp;
    logic [14:0] first_param;
    logic [14:0] second_param;
    logic [7:0]  events_so_far;
    logic        overflow_seen;
    logic        last_of_item;
  } evt_word_t;

endpackage
`default_nettype wire

// File: sv/vced_obs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vced_obs_if
// Observation channel: one voice observation per word.
// ----------------------------------------------------------------------------
interface vced_obs_if;
  logic        valid;
  logic        ready;
  logic [2:0]  voice_index;
  logic        frame_start;
  logic [47:0] frame_stamp;
  logic        voice_active;
  logic [1:0]  env_phase;
  logic [10:0] env_level;
  logic [7:0]  sample_source;
  logic [14:0] eff_pitch;
  logic [7:0]  vol_left;
  logic [7:0]  vol_right;
  logic [2:0]  voice_flags;

  modport source (
    output valid, voice_index, frame_start, frame_stamp, voice_active, env_phase,
           env_level, sample_source, eff_pitch, vol_left, vol_right, voice_flags,
    input  ready
  );
  modport sink (
    input  valid, voice_index, frame_start, frame_stamp, voice_active, env_phase,
           env_level, sample_source, eff_pitch, vol_left, vol_right, voice_flags,
    output ready
  );
endinterface
`default_nettype wire

// File: sv/vced_evt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vced_evt_if
// Event channel: one event or status word per transfer.
// ----------------------------------------------------------------------------
interface vced_evt_if;
  logic        valid;
  logic        ready;
  logic        event_valid;
  logic [3:0]  event_kind;
  logic [2:0]  event_voice;
  logic [47:0] event_stamp;
  logic [14:0] first_param;
  logic [14:0] second_param;
  logic [7:0]  events_so_far;
  logic        overflow_seen;
  logic        last_of_item;

  modport source (
    output valid, event_valid, event_kind, event_voice, event_stamp, first_param,
           second_param, events_so_far, overflow_seen, last_of_item,
    input  ready
  );
  modport sink (
    input  valid, event_valid, event_kind, event_voice, event_stamp, first_param,
           second_param, events_so_far, overflow_seen, last_of_item,
    output ready
  );
endinterface
`default_nettype wire

// File: sv/voice_change_event_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voice_change_event_detector
// Compares each voice observation with the last one seen for that voice and
// reports key-on, release, end, source, pitch, volume and flag changes, with
// a per-frame event limit and overflow flag.
// ----------------------------------------------------------------------------
//   channel  dir  protocol       word
//   obs      in   valid/ready    one voice observation
//   evt      out  valid/ready    one event, or one status word
//   apb      in   APB, 3b addr   event_capacity (0x0), release_mode_code (0x4)
//
// An observation gives the emitter one word per event it produces, or a single
// status word when it produces none (1 to 9 words), via the single output
// register that the emitter fills one word per cycle while evt does not stall.
// The next observation is taken in the cycle its predecessor's last word is
// loaded, so observations that cause one word each flow at one per cycle while
// evt does not stall. Reset clears the voice history, frame count and overflow
// flag. A stall on evt holds the output word and, while busy, obs.ready.
// ----------------------------------------------------------------------------
module voice_change_event_detector (
  input  logic                          clk,
  input  logic                          rst,
  vced_obs_if.sink                      obs,
  vced_evt_if.source                    evt,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vced_pkg::ADDR_W-1:0]   paddr,
  input  logic [vced_pkg::DATA_W-1:0]   pwdata,
  output logic [vced_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import vced_pkg::*;

  cfg_t      cfg;
  obs_word_t obs_word;
  item_t     item;
  logic      load_ok;
  logic      take;
  logic      out_valid;
  evt_word_t out_word;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity     <= CAPACITY_RESET;
      cfg.release_code <= RELEASE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_CAPACITY: cfg.capacity     <= pwdata[7:0];
        REG_RELEASE:  cfg.release_code <= pwdata[1:0];
        default:      cfg.capacity     <= cfg.capacity;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAPACITY: prdata = {24'd0, cfg.capacity};
      REG_RELEASE:  prdata = {30'd0, cfg.release_code};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    obs_word.voice_index   = obs.voice_index;
    obs_word.frame_start   = obs.frame_start;
    obs_word.frame_stamp   = obs.frame_stamp;
    obs_word.voice_active  = obs.voice_active;
    obs_word.env_phase     = obs.env_phase;
    obs_word.env_level     = obs.env_level;
    obs_word.sample_source = obs.sample_source;
    obs_word.eff_pitch     = obs.eff_pitch;
    obs_word.vol_left      = obs.vol_left;
    obs_word.vol_right     = obs.vol_right;
    obs_word.voice_flags   = obs.voice_flags;
  end

  assign obs.ready = load_ok;
  assign take      = obs.valid && load_ok;

  vced_compare u_compare (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .obs  (obs_word),
    .take (take),
    .item (item)
  );

  vced_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (obs.valid),
    .item_in    (item),
    .load_ok    (load_ok),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .out_ready  (evt.ready)
  );

  assign evt.valid         = out_valid;
  assign evt.event_valid   = out_word.event_valid;
  assign evt.event_kind    = out_word.event_kind;
  assign evt.event_voice   = out_word.event_voice;
  assign evt.event_stamp   = out_word.event_stamp;
  assign evt.first_param   = out_word.first_param;
  assign evt.second_param  = out_word.second_param;
  assign evt.events_so_far = out_word.events_so_far;
  assign evt.overflow_seen = out_word.overflow_seen;
  assign evt.last_of_item  = out_word.last_of_item;

endmodule
`default_nettype wire

// File: sv/vced_compare.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vced_compare
// Holds the last observation of every voice and compares an incoming word
// against it, giving the mask of events that the word causes. The stored
// observation is replaced at the edge that accepts the word.
// ----------------------------------------------------------------------------
module vced_compare (
  input  logic                clk,
  input  logic                rst,
  input  vced_pkg::cfg_t      cfg,
  input  vced_pkg::obs_word_t obs,
  input  logic                take,
  output vced_pkg::item_t     item
);
  import vced_pkg::*;

  voice_obs_t         prev_q [VOICE_COUNT];
  logic [VOICE_W-1:0] vidx;
  logic               hit;
  voice_obs_t         prev;
  voice_obs_t         cur;
  logic [14:0]        dp;
  logic [2:0]         tog;
  logic [NUM_KINDS-1:0] mask;

  always_comb begin
    vidx = VOICE_W'(obs.voice_index);
    hit  = 7'(obs.voice_index) < 7'(VOICE_COUNT);
    prev = prev_q[vidx];

    cur.active = obs.voice_active;
    cur.phase  = obs.env_phase;
    cur.source = obs.sample_source;
    cur.pitch  = obs.eff_pitch;
    cur.vol_l  = obs.vol_left;
    cur.vol_r  = obs.vol_right;
    cur.flags  = obs.voice_flags;

    dp  = (cur.pitch >= prev.pitch) ? (cur.pitch - prev.pitch) : (prev.pitch - cur.pitch);
    tog = prev.flags ^ cur.flags;

    mask               = '0;
    mask[KIND_KEYON]   = !prev.active && cur.active;
    mask[KIND_RELEASE] = (prev.phase != cfg.release_code) && (cur.phase == cfg.release_code);
    mask[KIND_END]     = prev.active && !cur.active;
    mask[KIND_SOURCE]  = prev.source != cur.source;
    mask[KIND_PITCH]   = dp > 15'd1;
    mask[KIND_VOLUME]  = (prev.vol_l != cur.vol_l) || (prev.vol_r != cur.vol_r);
    mask[KIND_NOISE]   = tog[0];
    mask[KIND_PMOD]    = tog[1];
    mask[KIND_ECHO]    = tog[2];
    // Voice numbers beyond the voice count are reported with a status word only.
    if (!hit) begin
      mask = '0;
    end

    item.voice       = obs.voice_index;
    item.frame_start = obs.frame_start;
    item.stamp       = obs.frame_stamp;
    item.level       = obs.env_level;
    item.cur         = cur;
    item.old_source  = prev.source;
    item.old_pitch   = prev.pitch;
    item.mask        = mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        prev_q[i] <= '0;
      end
    end else if (take && hit) begin
      prev_q[vidx] <= cur;
    end
  end

endmodule
`default_nettype wire

// File: sv/vced_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vced_emit
// Walks the event mask of one item, one event per cycle unless stalled, keeps
// the per-frame event count and overflow flag, and drives the output register.
// ----------------------------------------------------------------------------
module vced_emit (
  input  logic                clk,
  input  logic                rst,
  input  vced_pkg::cfg_t      cfg,
  input  logic                item_valid,
  input  vced_pkg::item_t     item_in,
  output logic                load_ok,
  output logic                out_valid,
  output vced_pkg::evt_word_t out_word,
  input  logic                out_ready
);
  import vced_pkg::*;

  logic                 busy;
  logic                 first;
  item_t                item_q;
  logic [NUM_KINDS-1:0] mask_q;
  logic [7:0]           count;
  logic                 ovf;

  logic                 adv;
  logic                 clr;
  logic [7:0]           cnt_eff;
  logic                 ovf_eff;
  logic [3:0]           kind_idx;
  logic [NUM_KINDS-1:0] rest;
  logic                 any;
  logic                 can_emit;
  logic [7:0]           cnt_inc;
  logic                 last;
  logic [7:0]           cnt_next;
  logic                 ovf_next;
  evt_word_t            res;

  always_comb begin
    adv     = busy && (!out_valid || out_ready);
    clr     = first && item_q.frame_start;
    cnt_eff = clr ? 8'd0 : count;
    ovf_eff = clr ? 1'b0 : ovf;

    kind_idx = 4'd0;
    for (int i = NUM_KINDS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        kind_idx = 4'(i);
      end
    end
    rest     = mask_q & (mask_q - 1'b1);
    any      = mask_q != '0;
    can_emit = any && (cnt_eff < cfg.capacity);
    cnt_inc  = cnt_eff + 8'd1;

    // Once the count reaches capacity the remaining events of the item drop.
    last     = can_emit ? ((rest == '0) || (cnt_inc >= cfg.capacity)) : 1'b1;
    cnt_next = can_emit ? cnt_inc : cnt_eff;
    ovf_next = can_emit ? (ovf_eff | (last && (rest != '0))) : (ovf_eff | any);

    res.event_valid   = can_emit;
    res.event_kind    = can_emit ? kind_idx : KIND_KEYON;
    res.event_voice   = item_q.voice;
    res.event_stamp   = item_q.stamp;
    res.first_param   = '0;
    res.second_param  = '0;
    res.events_so_far = cnt_next;
    res.overflow_seen = can_emit ? ovf_eff : ovf_next;
    res.last_of_item  = last;
    if (can_emit) begin
      case (event_kind_t'(kind_idx))
        KIND_KEYON: begin
          res.first_param = 15'(item_q.cur.source);
        end
        KIND_RELEASE, KIND_END: begin
          res.first_param = 15'(item_q.level);
        end
        KIND_SOURCE: begin
          res.first_param  = 15'(item_q.cur.source);
          res.second_param = 15'(item_q.old_source);
        end
        KIND_PITCH: begin
          res.first_param  = item_q.cur.pitch;
          res.second_param = item_q.old_pitch;
        end
        KIND_VOLUME: begin
          res.first_param  = 15'(item_q.cur.vol_l);
          res.second_param = 15'(item_q.cur.vol_r);
        end
        KIND_NOISE: begin
          res.first_param = 15'(item_q.cur.flags[0]);
        end
        KIND_PMOD: begin
          res.first_param = 15'(item_q.cur.flags[1]);
        end
        KIND_ECHO: begin
          res.first_param = 15'(item_q.cur.flags[2]);
        end
        default: begin
          res.first_param = '0;
        end
      endcase
    end

    load_ok = !busy || (adv && last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      first     <= 1'b0;
      count     <= 8'd0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        count     <= cnt_next;
        ovf       <= ovf_next;
        out_valid <= 1'b1;
        out_word  <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_ok) begin
        busy <= item_valid;
      end
      // A new item replaces the walked mask; otherwise each loaded word steps it on.
      if (load_ok && item_valid) begin
        item_q <= item_in;
        mask_q <= item_in.mask;
        first  <= 1'b1;
      end else if (adv) begin
        mask_q <= rest;
        first  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/vced_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vced_checker
// Port-level checks on the event channel of the voice change event detector.
// ----------------------------------------------------------------------------
module vced_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        evt_valid,
  input  wire        evt_ready,
  input  wire        event_valid,
  input  wire [3:0]  event_kind,
  input  wire [47:0] event_stamp,
  input  wire [7:0]  events_so_far,
  input  wire        last_of_item
);

  // A stalled word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(event_kind) &&
      $stable(event_stamp) && $stable(events_so_far))
    else $error("event word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !evt_valid)
    else $error("event word presented right after reset");

  // Words of one observation follow each other without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready && !last_of_item |=> evt_valid)
    else $error("gap inside the words of one observation");

  // Within one observation each further word is an event that adds one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready && !last_of_item |=> event_valid &&
      events_so_far == $past(events_so_far) + 8'd1 &&
      event_stamp == $past(event_stamp))
    else $error("event count or stamp broke within one observation");

endmodule

bind voice_change_event_detector vced_checker u_vced_checker (
  .clk           (clk),
  .rst           (rst),
  .evt_valid     (evt.valid),
  .evt_ready     (evt.ready),
  .event_valid   (evt.event_valid),
  .event_kind    (evt.event_kind),
  .event_stamp   (evt.event_stamp),
  .events_so_far (evt.events_so_far),
  .last_of_item  (evt.last_of_item)
);
`default_nettype wire
